// ----- rtl/sntab_pkg.sv -----
// shared types, codes and widths for the sorted name table engine
package sntab_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_LSRCH  = 3'd2;
  localparam logic [2:0] KIND_SORT   = 3'd3;
  localparam logic [2:0] KIND_BSRCH  = 3'd4;
  localparam logic [2:0] KIND_READ   = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADINDEX = 3'd4;

  localparam logic [6:0] CMP_MAX = 7'd127;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         entry_index;
    logic [63:0]        key_word_0;
    logic [63:0]        key_word_1;
    logic [63:0]        key_word_2;
    logic [63:0]        key_word_3;
    logic [63:0]        class_word_0;
    logic [63:0]        class_word_1;
    logic [63:0]        class_word_2;
    logic signed [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         position;
    logic [6:0]         comparisons;
    logic [4:0]         entry_count;
    logic [63:0]        found_name_0;
    logic [63:0]        found_name_1;
    logic [63:0]        found_name_2;
    logic [63:0]        found_name_3;
    logic [63:0]        found_class_0;
    logic [63:0]        found_class_1;
    logic [63:0]        found_class_2;
    logic signed [31:0] found_amount;
  } rsp_t;

  // one stored record; name words first so the top 256 bits order as names
  typedef struct packed {
    logic [255:0] name;
    logic [191:0] cls;
    logic [31:0]  amount;
  } rec_t;

endpackage

// ----- rtl/sorted_name_table_engine.sv -----
// sorted name table engine: record memory, shared key comparator and op sequencer
// operations: insert writes as it is taken, read entry reads one record, linear search/remove
//   walk record by record, binary search probes midpoints, sort makes 120 compares at 16
// throughput: one item at a time; the record memory (one read, one write per cycle)
//   and the 256-bit key comparator are shared by every step of an operation
// reset: synchronous, clears the record count and control; record memory is not cleared
module sorted_name_table_engine #(
  parameter int DEPTH = sntab_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  sntab_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output sntab_pkg::rsp_t  rsp
);
  import sntab_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // record memory
  rec_t            mem [DEPTH];
  rec_t            rdata;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  rec_t            wdata;

  // sequencer and working registers
  logic [2:0]      state;
  logic [2:0]      op;
  logic [255:0]    key;
  logic [CW-1:0]   count;
  logic [CW-1:0]   ptr;
  logic [CW-1:0]   lim;
  logic [CW-1:0]   lo;
  logic [CW-1:0]   hp;
  logic            loading;
  logic            shifting;
  rec_t            carry;
  rec_t            found;
  logic [2:0]      st;
  logic [3:0]      pos;
  logic [6:0]      cmps;

  logic            accept;
  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid;
  logic            key_eq;
  logic            key_lt;
  logic            carry_gt;
  logic [CW+3:0]   ptr_wide;
  logic [CW+3:0]   mid_wide;
  logic [CW+4:0]   cnt_wide;
  logic [CW+3:0]   eidx_wide;
  logic [6:0]      cmps_inc;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  assign mid_sum   = {1'b0, lo} + {1'b0, hp} - {{CW{1'b0}}, 1'b1};
  assign mid       = mid_sum[CW:1];

  // shared comparator: probe key against read record, or carried record against it
  assign key_eq    = (key == rdata.name);
  assign key_lt    = (key <  rdata.name);
  assign carry_gt  = (carry.name > rdata.name);

  assign ptr_wide  = {4'd0, ptr};
  assign mid_wide  = {4'd0, mid};
  assign cnt_wide  = {5'd0, count};
  assign eidx_wide = {{CW{1'b0}}, req.entry_index};
  assign cmps_inc  = (cmps == CMP_MAX) ? cmps : cmps + 7'd1;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // read address: mid for binary search, the entry index for read entry, else the walking pointer
  always_comb begin
    if (op == KIND_BSRCH) begin
      raddr = mid[AW-1:0];
    end else if (op == KIND_READ) begin
      raddr = lim[AW-1:0];
    end else begin
      raddr = ptr[AW-1:0];
    end
  end

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = carry;
    unique case (state)
      S_IDLE: begin
        if (accept && req.kind == KIND_INSERT && cnt_wide < (CW + 5)'(DEPTH)) begin
          we    = 1'b1;
          waddr = count[AW-1:0];
          wdata = '{name:   {req.key_word_0, req.key_word_1, req.key_word_2,
                             req.key_word_3},
                    cls:    {req.class_word_0, req.class_word_1, req.class_word_2},
                    amount: req.amount};
        end
      end
      S_EXEC: begin
        if (op == KIND_REMOVE && shifting) begin
          we    = 1'b1;
          waddr = ptr[AW-1:0] - 1'b1;
          wdata = rdata;
        end else if (op == KIND_SORT && !loading) begin
          // smaller of the pair settles at the lower slot
          we    = 1'b1;
          waddr = ptr[AW-1:0] - 1'b1;
          wdata = carry_gt ? rdata : carry;
        end
      end
      S_WB: begin
        we    = 1'b1;
        waddr = ptr[AW-1:0];
        wdata = carry;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // output register empties on a transfer unless a new response lands now
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= req.kind;
            key      <= {req.key_word_0, req.key_word_1, req.key_word_2, req.key_word_3};
            found    <= '0;
            st       <= ST_OK;
            pos      <= '0;
            cmps     <= '0;
            ptr      <= '0;
            lo       <= '0;
            hp       <= count;
            lim      <= count - 1'b1;
            loading  <= 1'b1;
            shifting <= 1'b0;
            state    <= S_DONE;
            priority case (req.kind)
              KIND_INSERT: begin
                if (cnt_wide >= (CW + 5)'(DEPTH)) begin
                  st <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                end
              end
              KIND_REMOVE: begin
                if (count == '0) begin
                  st <= ST_EMPTY;
                end else begin
                  state <= S_READ;
                end
              end
              KIND_LSRCH, KIND_BSRCH: begin
                st <= ST_NOTFOUND;
                if (count != '0) begin
                  state <= S_READ;
                end
              end
              KIND_SORT: begin
                if (count > (CW)'(1)) begin
                  state <= S_READ;
                end
              end
              KIND_READ: begin
                if (eidx_wide >= {4'd0, count}) begin
                  st <= ST_BADINDEX;
                end else begin
                  lim   <= eidx_wide[CW-1:0];
                  pos   <= req.entry_index;
                  state <= S_READ;
                end
              end
              default: begin
                st <= ST_OK;
              end
            endcase
          end
        end

        S_READ: begin
          state <= S_EXEC;
        end

        S_EXEC: begin
          state <= S_READ;
          unique case (op)
            KIND_READ: begin
              found <= rdata;
              state <= S_DONE;
            end
            KIND_LSRCH: begin
              cmps <= cmps_inc;
              if (key_eq) begin
                st    <= ST_OK;
                pos   <= ptr_wide[3:0];
                found <= rdata;
                state <= S_DONE;
              end else if (ptr + 1'b1 == count) begin
                state <= S_DONE;
              end
              ptr <= ptr + 1'b1;
            end
            KIND_REMOVE: begin
              if (!shifting) begin
                if (key_eq) begin
                  st       <= ST_OK;
                  pos      <= ptr_wide[3:0];
                  found    <= rdata;
                  shifting <= 1'b1;
                  if (ptr + 1'b1 == count) begin
                    count <= count - 1'b1;
                    state <= S_DONE;
                  end
                end else if (ptr + 1'b1 == count) begin
                  st    <= ST_NOTFOUND;
                  state <= S_DONE;
                end
                ptr <= ptr + 1'b1;
              end else begin
                // later record moved down one slot this cycle
                if (ptr + 1'b1 == count) begin
                  count <= count - 1'b1;
                  state <= S_DONE;
                end
                ptr <= ptr + 1'b1;
              end
            end
            KIND_BSRCH: begin
              cmps <= cmps_inc;
              if (key_eq) begin
                st    <= ST_OK;
                pos   <= mid_wide[3:0];
                found <= rdata;
                state <= S_DONE;
              end else if (key_lt) begin
                hp <= mid;
                if (lo >= mid) begin
                  state <= S_DONE;
                end
              end else begin
                lo <= mid + 1'b1;
                if (mid + 1'b1 >= hp) begin
                  state <= S_DONE;
                end
              end
            end
            KIND_SORT: begin
              if (loading) begin
                carry   <= rdata;
                loading <= 1'b0;
                ptr     <= (CW)'(1);
              end else begin
                cmps <= cmps_inc;
                if (!carry_gt) begin
                  carry <= rdata;
                end
                if (ptr == lim) begin
                  state <= S_WB;
                end else begin
                  ptr <= ptr + 1'b1;
                end
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end

        S_WB: begin
          // end of a pass: largest record lands at the top slot
          if (lim == (CW)'(1)) begin
            state <= S_DONE;
          end else begin
            lim     <= lim - 1'b1;
            ptr     <= '0;
            loading <= 1'b1;
            state   <= S_READ;
          end
        end

        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp       <= '{status:        st,
                           position:      pos,
                           comparisons:   cmps,
                           entry_count:   cnt_wide[4:0],
                           found_name_0:  found.name[255:192],
                           found_name_1:  found.name[191:128],
                           found_name_2:  found.name[127:64],
                           found_name_3:  found.name[63:0],
                           found_class_0: found.cls[191:128],
                           found_class_1: found.cls[127:64],
                           found_class_2: found.cls[63:0],
                           found_amount:  found.amount};
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sim/sorted_name_table_checker.sv -----
// checker for the sorted name table engine: predicts each response and compares it
`timescale 1ns / 100ps
module sorted_name_table_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_stall,
  input  sntab_pkg::req_t req,
  input  logic            rsp_valid,
  input  logic            rsp_stall,
  input  sntab_pkg::rsp_t rsp,
  output int              fail_count,
  output int              pending
);
  import sntab_pkg::*;

  localparam int TBL_DEPTH = DEPTH_DEF;

  rec_t table_mem [TBL_DEPTH];
  int   held;
  rsp_t expected_rsps [$];

  assign pending = expected_rsps.size();

  function automatic int name_order(logic [255:0] a, logic [255:0] b);
    if (a < b) return -1;
    if (a > b) return 1;
    return 0;
  endfunction

  function automatic rsp_t record_out(rsp_t r, rec_t x);
    r.found_name_0  = x.name[255:192];
    r.found_name_1  = x.name[191:128];
    r.found_name_2  = x.name[127:64];
    r.found_name_3  = x.name[63:0];
    r.found_class_0 = x.cls[191:128];
    r.found_class_1 = x.cls[127:64];
    r.found_class_2 = x.cls[63:0];
    r.found_amount  = x.amount;
    return r;
  endfunction

  task automatic predict_table_op(req_t q);
    rsp_t         r;
    logic [255:0] key;
    int           cmps, lo, hi, mid, c, i, j;
    rec_t         t;
    r    = '0;
    cmps = 0;
    key  = {q.key_word_0, q.key_word_1, q.key_word_2, q.key_word_3};
    case (q.kind)
      KIND_INSERT: begin
        if (held >= TBL_DEPTH) r.status = ST_FULL;
        else begin
          table_mem[held] = {key, q.class_word_0, q.class_word_1, q.class_word_2, q.amount};
          held++;
        end
      end
      KIND_REMOVE: begin
        if (held == 0) r.status = ST_EMPTY;
        else begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < held; i++) begin
            if (table_mem[i].name == key) begin
              r.status   = ST_OK;
              r.position = 4'(i);
              r          = record_out(r, table_mem[i]);
              for (j = i; j + 1 < held; j++) table_mem[j] = table_mem[j + 1];
              held--;
              break;
            end
          end
        end
      end
      KIND_LSRCH: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < held; i++) begin
          cmps++;
          if (table_mem[i].name == key) begin
            r.status   = ST_OK;
            r.position = 4'(i);
            r          = record_out(r, table_mem[i]);
            break;
          end
        end
      end
      KIND_SORT: begin
        for (i = 0; i + 1 < held; i++)
          for (j = 0; j + 1 < held - i; j++) begin
            cmps++;
            if (table_mem[j].name > table_mem[j + 1].name) begin
              t                = table_mem[j];
              table_mem[j]     = table_mem[j + 1];
              table_mem[j + 1] = t;
            end
          end
      end
      KIND_BSRCH: begin
        r.status = ST_NOTFOUND;
        lo = 0;
        hi = held - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          cmps++;
          c = name_order(key, table_mem[mid].name);
          if (c == 0) begin
            r.status   = ST_OK;
            r.position = 4'(mid);
            r          = record_out(r, table_mem[mid]);
            break;
          end
          if (c < 0) hi = mid - 1;
          else lo = mid + 1;
        end
      end
      KIND_READ: begin
        if (q.entry_index >= held) r.status = ST_BADINDEX;
        else begin
          r.position = q.entry_index;
          r          = record_out(r, table_mem[q.entry_index]);
        end
      end
      default: ;
    endcase
    r.comparisons = (cmps > int'(CMP_MAX)) ? CMP_MAX : 7'(cmps);
    r.entry_count = 5'(held);
    expected_rsps.push_back(r);
  endtask

  task automatic check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h actual %0h", fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      held <= 0;
      fail_count <= 0;
    end else begin
      if (req_valid && !req_stall) predict_table_op(req);
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("response transfer with nothing expected");
          fail_count++;
        end else begin
          e = expected_rsps.pop_front();
          check_field("status", 64'(e.status), 64'(rsp.status));
          check_field("position", 64'(e.position), 64'(rsp.position));
          check_field("comparisons", 64'(e.comparisons), 64'(rsp.comparisons));
          check_field("entry_count", 64'(e.entry_count), 64'(rsp.entry_count));
          check_field("found_name_0", e.found_name_0, rsp.found_name_0);
          check_field("found_name_1", e.found_name_1, rsp.found_name_1);
          check_field("found_name_2", e.found_name_2, rsp.found_name_2);
          check_field("found_name_3", e.found_name_3, rsp.found_name_3);
          check_field("found_class_0", e.found_class_0, rsp.found_class_0);
          check_field("found_class_1", e.found_class_1, rsp.found_class_1);
          check_field("found_class_2", e.found_class_2, rsp.found_class_2);
          check_field("found_amount", 64'(e.found_amount), 64'(rsp.found_amount));
        end
      end
    end
  end
endmodule

// ----- sim/sorted_name_table_engine_test.sv -----
// stimulus and verdict for the sorted name table engine
`timescale 1ns / 100ps
module sorted_name_table_engine_test;
  import sntab_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  int   fail_count;
  int   pending;
  logic quiet = 1'b0;     // last part of the run: no idling at all
  logic hold_long = 1'b0; // receiver holds off for a long stretch

  // small pool of names so searches and removes hit often
  logic [255:0] name_pool [8];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_name_table_engine u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  sorted_name_table_checker u_chk (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random name: either from the pool or fully random bits, padding included
  function automatic logic [255:0] pick_name();
    if ($urandom_range(0, 3) != 0) return name_pool[$urandom_range(0, 7)];
    return {rand64(), rand64(), rand64(), rand64()};
  endfunction

  // one transfer on the request side; valid stays high across back-to-back items
  task automatic send_op(logic [2:0] k, logic [3:0] idx, logic [255:0] nm, int gap_ok);
    req_t q;
    int   n;
    if (gap_ok && !quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 13);
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    q.kind         = k;
    q.entry_index  = idx;
    {q.key_word_0, q.key_word_1, q.key_word_2, q.key_word_3} = nm;
    q.class_word_0 = rand64();
    q.class_word_1 = rand64();
    q.class_word_2 = rand64();
    q.amount       = $urandom;
    req       <= q;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, a long hold on request, none when quiet
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        rsp_stall <= 1'b1;
        for (n = 0; n < 3000; n++) @(posedge clk);
        hold_long <= 1'b0;
        rsp_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 13);
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    int           i, k;
    logic [255:0] nm;
    for (i = 0; i < 8; i++) name_pool[i] = {rand64(), rand64(), rand64(), rand64()};
    name_pool[0] = '0;
    name_pool[1] = '1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table cases, extremes, fill to full, sort, search, read
    send_op(KIND_REMOVE, 0, name_pool[0], 0);
    send_op(KIND_LSRCH, 0, name_pool[0], 0);
    send_op(KIND_BSRCH, 0, name_pool[0], 0);
    send_op(KIND_SORT, 0, '0, 0);
    send_op(KIND_READ, 0, '0, 0);
    send_op(3'd6, 0, '0, 0);
    send_op(3'd7, 4'hf, '1, 0);
    send_op(KIND_INSERT, 0, name_pool[1], 0);
    send_op(KIND_SORT, 0, '0, 0);
    for (i = 0; i < 15; i++) send_op(KIND_INSERT, 0, name_pool[i % 8], 0);
    send_op(KIND_INSERT, 0, name_pool[2], 0);
    send_op(KIND_READ, 4'hf, '0, 0);
    send_op(KIND_BSRCH, 0, name_pool[3], 0);
    send_op(KIND_SORT, 0, '0, 0);
    send_op(KIND_BSRCH, 0, name_pool[3], 0);
    send_op(KIND_LSRCH, 0, name_pool[1], 0);
    send_op(KIND_REMOVE, 0, name_pool[0], 0);
    send_op(KIND_READ, 4'hf, '0, 0);
    wait_drained();

    // long receiver hold while requests keep coming
    hold_long <= 1'b1;
    for (i = 0; i < 20; i++) send_op(KIND_READ, 4'($urandom_range(0, 15)), '0, 0);
    wait_drained();

    // random: mostly inserts and lookups on pool names, sorts now and then
    for (i = 0; i < 850; i++) begin
      if (i == 700) quiet <= 1'b1;
      k  = $urandom_range(0, 99);
      nm = pick_name();
      if (k < 30) send_op(KIND_INSERT, 0, nm, 1);
      else if (k < 48) send_op(KIND_REMOVE, 0, nm, 1);
      else if (k < 62) send_op(KIND_LSRCH, 0, nm, 1);
      else if (k < 70) send_op(KIND_SORT, 0, nm, 1);
      else if (k < 84) send_op(KIND_BSRCH, 0, nm, 1);
      else if (k < 98) send_op(KIND_READ, 4'($urandom_range(0, 15)), nm, 1);
      else send_op(3'($urandom_range(6, 7)), 4'($urandom_range(0, 15)), nm, 1);
    end
    wait_drained();
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #10000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
